### rtl/core/lfps_pkg.sv
// Package with the shared types and constants of the line-following steering block.
package lfps_pkg;

  localparam int unsigned ERR_W = 16;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned GAIN_W = 11;
  localparam int unsigned BASE_W = 8;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned RAND_W = 3;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned Q_SHIFT = 14;

  localparam logic signed [ERR_W-1:0] ERR_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_BASE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_ON     = 2'd1,
    MODE_LOST   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    MOOD_NONE  = 2'd0,
    MOOD_HAPPY = 2'd1,
    MOOD_SAD   = 2'd2
  } mood_t;

  typedef struct packed {
    logic                     line_found;
    logic signed [ERR_W-1:0]  line_error;
    logic [RAND_W-1:0]        random_left;
    logic [RAND_W-1:0]        random_right;
  } meas_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] wheel_left;
    logic signed [SPEED_W-1:0] wheel_right;
    mood_t                     mood_event;
    logic                      steering;
  } cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_proportional;
    logic signed [GAIN_W-1:0] gain_integral;
    logic signed [GAIN_W-1:0] gain_derivative;
    logic signed [BASE_W-1:0] base_speed;
  } cfg_t;

  // Snapshot of one transaction after the error tracking stage.
  typedef struct packed {
    logic                     pid;
    mood_t                    mood;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ERR_W:0]    diff;
    logic [RAND_W-1:0]        rand_l;
    logic [RAND_W-1:0]        rand_r;
  } track_t;

endpackage

### rtl/core/lfps_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
interface lfps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/lfps_regs.sv
// APB-style configuration registers holding the gains and the base speed.
module lfps_regs
  import lfps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN_P: cfg.gain_proportional <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: cfg.gain_integral <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: cfg.gain_derivative <= pwdata[GAIN_W-1:0];
        REG_BASE:   cfg.base_speed <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P: prdata = DATA_W'(cfg.gain_proportional);
      REG_GAIN_I: prdata = DATA_W'(cfg.gain_integral);
      REG_GAIN_D: prdata = DATA_W'(cfg.gain_derivative);
      REG_BASE:   prdata = DATA_W'(cfg.base_speed);
      default:    prdata = '0;
    endcase
  end

endmodule

### rtl/core/lfps_track.sv
// Mode tracking and error state update, one transaction per cycle while the output is not stalled.
module lfps_track
  import lfps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  meas_t  in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output track_t out_data
);

  mode_t                   mode;
  mode_t                   mode_next;
  logic signed [ERR_W-1:0] held;
  logic signed [ERR_W-1:0] last;
  logic signed [SUM_W-1:0] sum;

  logic signed [ERR_W-1:0] held_next;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  mood_t                   mood;
  logic                    pid;
  logic                    take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    mode_next = mode;
    if (in_data.line_found) begin
      mode_next = MODE_ON;
    end else if (mode == MODE_ON) begin
      mode_next = MODE_LOST;
    end
  end

  always_comb begin
    mood      = MOOD_NONE;
    held_next = held;
    if (in_data.line_found) begin
      if (mode != MODE_ON) begin
        mood = MOOD_HAPPY;
      end
      held_next = in_data.line_error;
    end else if (mode == MODE_ON) begin
      mood = MOOD_SAD;
      if (held > 0) begin
        held_next = ERR_ONE;
      end else if (held < 0) begin
        held_next = -ERR_ONE;
      end
    end
    pid = in_data.line_found || (mode != MODE_SEARCH);
  end

  always_comb begin
    sum_wide = (SUM_W+1)'(sum) + (SUM_W+1)'(held_next);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SEARCH;
      held      <= '0;
      last      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        mode <= mode_next;
        if (pid) begin
          held <= held_next;
          last <= held_next;
          sum  <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.pid    <= pid;
      out_data.mood   <= mood;
      out_data.err    <= held_next;
      out_data.sum    <= sum_next;
      out_data.diff   <= (ERR_W+1)'(held_next) - (ERR_W+1)'(last);
      out_data.rand_l <= in_data.random_left;
      out_data.rand_r <= in_data.random_right;
    end
  end

`ifndef SYNTHESIS
  a_lost_after_on: assert property (@(posedge clk) disable iff (rst)
    take && !in_data.line_found && mode == MODE_ON |=> mode == MODE_LOST)
    else $error("Losing the line while on it did not enter the lost mode.");

  a_sad_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mood == MOOD_SAD |->
      out_data.err == ERR_ONE || out_data.err == -ERR_ONE || out_data.err == '0)
    else $error("Held error after losing the line is not a sign value.");

  a_search_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pid |-> out_data.mood == MOOD_NONE)
    else $error("A search move carried a mood event.");

  a_search_frozen: assert property (@(posedge clk) disable iff (rst)
    take && !pid |=> $stable(sum) && $stable(last) && $stable(held))
    else $error("Error state changed during a search move.");
`endif

endmodule

### rtl/core/lfps_law.sv
// PID products, angle and wheel speed stages that end in the result register.
module lfps_law
  import lfps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  track_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output cmd_t   out_data
);

  localparam int unsigned P_W = GAIN_W + ERR_W;
  localparam int unsigned I_W = GAIN_W + SUM_W;
  localparam int unsigned D_W = GAIN_W + ERR_W + 1;
  localparam int unsigned ACC_W = I_W + 1;
  localparam int unsigned ANG_W = ACC_W - Q_SHIFT;
  localparam int unsigned WHL_W = ANG_W + 1;

  logic                  b_valid;
  logic                  b_ready;
  logic                  b_pid;
  mood_t                 b_mood;
  logic [RAND_W-1:0]     b_rand_l;
  logic [RAND_W-1:0]     b_rand_r;
  logic signed [P_W-1:0] b_p;
  logic signed [I_W-1:0] b_i;
  logic signed [D_W-1:0] b_d;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ANG_W-1:0] angle;
  logic signed [WHL_W-1:0] left_w;
  logic signed [WHL_W-1:0] right_w;
  cmd_t                    cmd_next;

  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [WHL_W-1:0] v);
    logic signed [WHL_W-1:0] hi;
    logic signed [WHL_W-1:0] lo;
    hi = WHL_W'({1'b0, {(SPEED_W-1){1'b1}}});
    lo = -hi - WHL_W'(1);
    if (v > hi) begin
      sat_speed = hi[SPEED_W-1:0];
    end else if (v < lo) begin
      sat_speed = lo[SPEED_W-1:0];
    end else begin
      sat_speed = v[SPEED_W-1:0];
    end
  endfunction

  assign b_ready  = !out_valid || out_ready;
  assign in_ready = !b_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        b_valid <= in_valid;
      end
      if (b_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_pid    <= in_data.pid;
      b_mood   <= in_data.mood;
      b_rand_l <= in_data.rand_l;
      b_rand_r <= in_data.rand_r;
      b_p      <= P_W'(cfg.gain_proportional) * P_W'(in_data.err);
      b_i      <= I_W'(cfg.gain_integral) * I_W'(in_data.sum);
      b_d      <= D_W'(cfg.gain_derivative) * D_W'(in_data.diff);
    end
  end

  always_comb begin
    acc     = ACC_W'(b_p) + ACC_W'(b_i) + ACC_W'(b_d);
    acc_adj = acc[ACC_W-1] ? acc + ACC_W'((1 << Q_SHIFT) - 1) : acc;
    angle   = ANG_W'(acc_adj >>> Q_SHIFT);
    left_w  = WHL_W'(cfg.base_speed) - WHL_W'(angle);
    right_w = WHL_W'(cfg.base_speed) + WHL_W'(angle);
    cmd_next.mood_event = b_mood;
    cmd_next.steering   = b_pid;
    if (b_pid) begin
      cmd_next.wheel_left  = sat_speed(left_w);
      cmd_next.wheel_right = sat_speed(right_w);
    end else begin
      cmd_next.wheel_left  = SPEED_W'({1'b0, b_rand_l} + (RAND_W+1)'(1));
      cmd_next.wheel_right = SPEED_W'({1'b0, b_rand_r} + (RAND_W+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) begin
      out_data <= cmd_next;
    end
  end

endmodule

### rtl/core/line_follow_pid_steering.sv
// Top level of the line-following PID steering block.
// Each meas transaction carries one frame's line measurement and yields exactly one cmd
// transaction with the two wheel speeds, a mood event and the steering flag. A transaction
// may be accepted in every cycle while cmd is not stalled; its result passes through three
// registered stages into the result register: the first updates the mode and, outside
// search moves, the held error, last error and saturating error sum, the second forms
// the three gain products, and the third sums them, scales by 1/16384 with truncation
// toward zero and saturates the wheel speeds, or takes random speeds plus one in search.
// Gains and base speed are to be written through the APB port only while no transaction
// is in flight; the block itself does not enforce this.
module line_follow_pid_steering
  import lfps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lfps_stream_if.sink       meas,
  lfps_stream_if.source     cmd,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   trk_valid;
  logic   trk_ready;
  track_t trk_data;
  meas_t  meas_data;
  cmd_t   cmd_data;

  assign meas_data   = meas.payload;
  assign cmd.payload = cmd_data;

  lfps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfps_track u_track (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .in_data   (meas_data),
    .out_valid (trk_valid),
    .out_ready (trk_ready),
    .out_data  (trk_data)
  );

  lfps_law u_law (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (trk_valid),
    .in_ready  (trk_ready),
    .in_data   (trk_data),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .out_data  (cmd_data)
  );

endmodule
